/* sv/drs_pkg.sv */
// Shared types and codes for the disk request scheduler.
// No dependencies; imported by drs_front, drs_back and the top level.
`default_nettype none
package drs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int BLOCK_BITS_DEF  = 24;

	localparam int IN_BLOCK_W  = 24;
	localparam int TAG_W       = 8;
	localparam int BUF_W       = 16;
	localparam int SEEK_W      = 24;
	localparam int TOTAL_W     = 40;
	localparam int PENDING_W   = 5;
	localparam int STATUS_W    = 2;
	localparam int POLICY_W    = 2;
	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 120;

	// command codes (s_tuser)
	localparam logic CMD_ENQUEUE  = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	// policy register codes; the unused code runs as FCFS
	localparam logic [POLICY_W-1:0] POL_FCFS  = 2'd0;
	localparam logic [POLICY_W-1:0] POL_CSCAN = 2'd1;
	localparam logic [POLICY_W-1:0] POL_SSTF  = 2'd2;

	// result status codes (m_tuser)
	localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

	typedef struct packed {
		logic                  command;
		logic                  is_read;
		logic [IN_BLOCK_W-1:0] block;
		logic [TAG_W-1:0]      task_tag;
		logic [BUF_W-1:0]      buffer_handle;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [IN_BLOCK_W-1:0] out_block;
		logic                  out_is_read;
		logic [TAG_W-1:0]      out_task_tag;
		logic [BUF_W-1:0]      out_buffer;
		logic [SEEK_W-1:0]     seek_distance;
		logic [TOTAL_W-1:0]    total_seek;
		logic [PENDING_W-1:0]  pending_count;
	} res_t;

endpackage
`default_nettype wire

/* sv/drs_front.sv */
// Front end: unpacks incoming command transactions and holds them in a
// two-entry queue for the back end. Depends on drs_pkg.
`default_nettype none
module drs_front
	import drs_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [S_TDATA_W-1:0] s_tdata,
	input  wire                  s_tuser,
	output logic                 cmd_valid,
	input  wire                  cmd_ready,
	output cmd_t                 cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       in_cmd;
	logic       push;
	logic       pop;

	always_comb begin
		in_cmd.command       = s_tuser;
		in_cmd.is_read       = s_tdata[0];
		in_cmd.block         = s_tdata[24:1];
		in_cmd.task_tag      = s_tdata[32:25];
		in_cmd.buffer_handle = s_tdata[48:33];
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/drs_back.sv */
// Back end: request memory, selection scan, compaction sweep, head and seek
// bookkeeping, and the result register. Depends on drs_pkg.
`default_nettype none
module drs_back
	import drs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [POLICY_W-1:0]  policy,
	input  wire                  cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output res_t                 res
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_PICK   = 3'd2;
	localparam logic [2:0] S_ADD    = 3'd3;
	localparam logic [2:0] S_SHIFT  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	typedef struct packed {
		logic                  is_read;
		logic [BLOCK_BITS-1:0] block;
		logic [TAG_W-1:0]      tag;
		logic [BUF_W-1:0]      buffer;
	} entry_t;

	entry_t                mem [QUEUE_DEPTH];
	entry_t                mem_rdata_q;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	entry_t                mem_wdata;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [BLOCK_BITS-1:0] head_q;
	logic [TOTAL_W-1:0]    total_q;

	logic [CW-1:0]         rd_q;
	logic                  rd_issue;
	logic                  rd_vld_s1;
	logic [CW-1:0]         rd_idx_s1;

	entry_t                best_q;
	logic [IW-1:0]         best_idx_q;
	logic [BLOCK_BITS-1:0] best_d_q;
	entry_t                hi_q;
	logic [IW-1:0]         hi_idx_q;
	logic                  hi_found_q;

	entry_t                sel_q;
	logic [IW-1:0]         sel_idx_q;
	logic [BLOCK_BITS-1:0] sd_q;

	res_t                  res_q;
	logic                  out_valid_q;

	entry_t                enq_ent;
	logic [31:0]           in_blk32;
	logic [BLOCK_BITS-1:0] rd_dist;
	logic                  rd_first;
	logic                  rd_last;
	logic                  rd_above;
	logic                  use_hi;
	entry_t                pick_ent;
	logic [IW-1:0]         pick_idx;
	logic [BLOCK_BITS-1:0] pick_dist;
	logic [TOTAL_W:0]      sum;
	logic [CW-1:0]         next_idx;
	logic [CW-1:0]         cnt_dec;
	logic [CW-1:0]         cnt_inc;
	logic [31:0]           sel_blk32;
	logic [31:0]           sd32;
	logic [31:0]           dec32;
	logic [31:0]           cur32;
	logic [31:0]           inc32;
	logic                  out_free;

	assign in_blk32 = 32'(cmd.block);
	always_comb begin
		enq_ent.is_read = cmd.is_read;
		enq_ent.block   = in_blk32[BLOCK_BITS-1:0];
		enq_ent.tag     = cmd.task_tag;
		enq_ent.buffer  = cmd.buffer_handle;
	end

	assign cnt_dec   = count_q - CW'(1);
	assign cnt_inc   = count_q + CW'(1);
	assign rd_issue  = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_q < count_q);
	assign rd_first  = (rd_idx_s1 == '0);
	assign rd_last   = (rd_idx_s1 == cnt_dec);
	assign rd_above  = (mem_rdata_q.block >= head_q);
	assign rd_dist   = rd_above ? (mem_rdata_q.block - head_q) : (head_q - mem_rdata_q.block);

	assign use_hi    = (policy == POL_CSCAN) && hi_found_q;
	assign pick_ent  = use_hi ? hi_q : best_q;
	assign pick_idx  = use_hi ? hi_idx_q : best_idx_q;
	assign pick_dist = (pick_ent.block >= head_q) ? (pick_ent.block - head_q)
	                                              : (head_q - pick_ent.block);

	// saturating total; the carry out marks overflow past 2^40 - 1
	assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(sd_q);
	assign next_idx  = CW'(sel_idx_q) + CW'(1);

	assign sel_blk32 = 32'(sel_q.block);
	assign sd32      = 32'(sd_q);
	assign dec32     = 32'(cnt_dec);
	assign cur32     = 32'(count_q);
	assign inc32     = 32'(cnt_inc);

	assign out_free  = !out_valid_q || m_tready;
	assign cmd_ready = (state_q == S_IDLE);

	// memory port: enqueue in idle, compaction writes during the sweep
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IW-1:0];
		mem_wdata = enq_ent;
		if (state_q == S_IDLE) begin
			mem_we = cmd_valid && (cmd.command == CMD_ENQUEUE) && (count_q != FULL);
		end else if (state_q == S_SHIFT) begin
			mem_we    = rd_vld_s1;
			mem_waddr = IW'(rd_idx_s1 - CW'(1));
			mem_wdata = mem_rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[rd_q[IW-1:0]];
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_q;
		if (state_q == S_SCAN && rd_vld_s1) begin
			case (policy)
				POL_SSTF: begin
					if (rd_first || rd_dist < best_d_q) begin
						best_q     <= mem_rdata_q;
						best_idx_q <= rd_idx_s1[IW-1:0];
						best_d_q   <= rd_dist;
					end
				end
				POL_CSCAN: begin
					// best_q tracks the overall minimum, hi_q the minimum at or above head
					if (rd_first || mem_rdata_q.block < best_q.block) begin
						best_q     <= mem_rdata_q;
						best_idx_q <= rd_idx_s1[IW-1:0];
					end
					if (rd_above && (rd_first || !hi_found_q ||
					                 mem_rdata_q.block < hi_q.block)) begin
						hi_q     <= mem_rdata_q;
						hi_idx_q <= rd_idx_s1[IW-1:0];
					end
				end
				default: begin
					if (rd_first) begin
						best_q     <= mem_rdata_q;
						best_idx_q <= rd_idx_s1[IW-1:0];
					end
				end
			endcase
		end
		if (state_q == S_PICK) begin
			sel_q     <= pick_ent;
			sel_idx_q <= pick_idx;
			sd_q      <= pick_dist;
		end
		if (state_q == S_IDLE && cmd_valid) begin
			res_q.out_block     <= '0;
			res_q.out_is_read   <= 1'b0;
			res_q.out_task_tag  <= '0;
			res_q.out_buffer    <= '0;
			res_q.seek_distance <= '0;
			res_q.total_seek    <= total_q;
			if (cmd.command == CMD_DISPATCH) begin
				res_q.status        <= ST_EMPTY;
				res_q.pending_count <= cur32[PENDING_W-1:0];
			end else if (count_q == FULL) begin
				res_q.status        <= ST_REJECTED;
				res_q.pending_count <= cur32[PENDING_W-1:0];
			end else begin
				res_q.status        <= ST_ACCEPTED;
				res_q.pending_count <= inc32[PENDING_W-1:0];
			end
		end
		if (state_q == S_FINISH) begin
			res_q.status        <= ST_DISPATCHED;
			res_q.out_block     <= sel_blk32[IN_BLOCK_W-1:0];
			res_q.out_is_read   <= sel_q.is_read;
			res_q.out_task_tag  <= sel_q.tag;
			res_q.out_buffer    <= sel_q.buffer;
			res_q.seek_distance <= sd32[SEEK_W-1:0];
			res_q.total_seek    <= total_q;
			res_q.pending_count <= dec32[PENDING_W-1:0];
		end
		if (state_q == S_RESULT && out_free) begin
			res <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			total_q     <= '0;
			rd_q        <= '0;
			rd_vld_s1   <= 1'b0;
			hi_found_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (rd_issue) rd_q <= rd_q + CW'(1);
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.command == CMD_DISPATCH && count_q != '0) begin
							rd_q       <= '0;
							hi_found_q <= 1'b0;
							state_q    <= S_SCAN;
						end else begin
							if (cmd.command == CMD_ENQUEUE && count_q != FULL) begin
								count_q <= cnt_inc;
							end
							state_q <= S_RESULT;
						end
					end
				end
				S_SCAN: begin
					if (rd_vld_s1 && rd_above && policy == POL_CSCAN) hi_found_q <= 1'b1;
					if (rd_vld_s1 && rd_last) state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					total_q <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
					head_q  <= sel_q.block;
					rd_q    <= next_idx;
					state_q <= (next_idx == count_q) ? S_FINISH : S_SHIFT;
				end
				S_SHIFT: begin
					if (rd_vld_s1 && rd_last) state_q <= S_FINISH;
				end
				S_FINISH: begin
					count_q <= cnt_dec;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

/* sv/disk_request_scheduler_core.sv */
// Top level of the disk request scheduler: policy register, front end,
// back end and stream packing. Depends on drs_pkg, drs_front, drs_back.
`default_nettype none
// Commands arrive on the s_ stream (tuser = 0 enqueue, 1 dispatch) and
// each produces exactly one result transaction on the m_ stream, in order.
// A two-entry command queue lets the front keep accepting while the back
// works or its result waits. Enqueue, reject and empty-dispatch go from
// idle straight to the result state; a dispatch walks the request memory
// once to select (one read per pending entry) and once more to close the
// gap behind the removed entry. The front queue registers each command
// before the back end sees it. The single memory read port sets how long
// a dispatch takes.
// Write cfg_wdata with cfg_wen only while no command is outstanding.
module disk_request_scheduler_core
	import drs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wen,
	input  wire  [POLICY_W-1:0]  cfg_wdata,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// is_read[0], block[24:1], task_tag[32:25], buffer_handle[48:33], zero pad
	input  wire  [S_TDATA_W-1:0] s_tdata,
	// command
	input  wire                  s_tuser,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	// out_block[23:0], out_is_read[24], out_task_tag[32:25], out_buffer[48:33],
	// seek_distance[72:49], total_seek[112:73], pending_count[117:113], zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// status
	output logic [STATUS_W-1:0]  m_tuser
);

	logic [POLICY_W-1:0] policy_q;
	logic                cmd_valid;
	logic                cmd_ready;
	cmd_t                cmd;
	res_t                res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
		end else if (cfg_wen) begin
			policy_q <= cfg_wdata;
		end
	end

	drs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	drs_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.BLOCK_BITS  (BLOCK_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {2'b00, res.pending_count, res.total_seek, res.seek_distance,
	                  res.out_buffer, res.out_task_tag, res.out_is_read, res.out_block};

endmodule
`default_nettype wire

/* sim/disk_request_scheduler_checker.sv */
// Checker for the disk request scheduler: watches the command and result streams,
// keeps its own copy of the request queue, head position and total seek, and compares
// every result. Depends on drs_pkg.
module disk_request_scheduler_checker
	import drs_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wen,
	input  wire  [POLICY_W-1:0]  cfg_wdata,
	input  wire                  s_tvalid,
	input  wire                  s_tready,
	input  wire  [S_TDATA_W-1:0] s_tdata,
	input  wire                  s_tuser,
	input  wire                  m_tvalid,
	input  wire                  m_tready,
	input  wire  [M_TDATA_W-1:0] m_tdata,
	input  wire  [STATUS_W-1:0]  m_tuser,
	output int                   mismatches,
	output int                   outstanding,
	output int                   n_results,
	output int                   n_dispatched,
	output int                   n_rejected,
	output int                   n_empty
);

	localparam int MAX_LINES = 40;

	logic [IN_BLOCK_W-1:0] req_block [QUEUE_DEPTH_DEF];
	logic                  req_read  [QUEUE_DEPTH_DEF];
	logic [TAG_W-1:0]      req_tag   [QUEUE_DEPTH_DEF];
	logic [BUF_W-1:0]      req_bh    [QUEUE_DEPTH_DEF];
	int                    req_count;
	logic [IN_BLOCK_W-1:0] head_pos;
	logic [TOTAL_W-1:0]    seek_sum;
	logic [POLICY_W-1:0]   cur_policy;
	res_t                  pending_results [$];

	function automatic logic [IN_BLOCK_W-1:0] seek_from_head(input logic [IN_BLOCK_W-1:0] b);
		return (b >= head_pos) ? b - head_pos : head_pos - b;
	endfunction

	// strict compares everywhere so equal keys keep the oldest request
	function automatic int select_request();
		int  best;
		bit  found;
		case (cur_policy)
			POL_SSTF: begin
				best = 0;
				for (int i = 1; i < req_count; i++)
					if (seek_from_head(req_block[i]) < seek_from_head(req_block[best]))
						best = i;
			end
			POL_CSCAN: begin
				best = 0;
				found = 1'b0;
				for (int i = 0; i < req_count; i++)
					if (req_block[i] >= head_pos && (!found || req_block[i] < req_block[best])) begin
						best = i;
						found = 1'b1;
					end
				// nothing ahead of the head: wrap to the lowest block
				if (!found) begin
					best = 0;
					for (int i = 1; i < req_count; i++)
						if (req_block[i] < req_block[best])
							best = i;
				end
			end
			default: best = 0;
		endcase
		return best;
	endfunction

	function automatic res_t predict_command(input logic cmd, input logic [S_TDATA_W-1:0] d);
		res_t                r;
		int                  k;
		logic [TOTAL_W:0]    sum;
		r = '0;
		if (cmd == CMD_ENQUEUE) begin
			if (req_count >= QUEUE_DEPTH_DEF) begin
				r.status = ST_REJECTED;
			end else begin
				req_read[req_count]  = d[0];
				req_block[req_count] = d[24:1];
				req_tag[req_count]   = d[32:25];
				req_bh[req_count]    = d[48:33];
				req_count++;
				r.status = ST_ACCEPTED;
			end
		end else if (req_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			k = select_request();
			r.status        = ST_DISPATCHED;
			r.out_block     = req_block[k];
			r.out_is_read   = req_read[k];
			r.out_task_tag  = req_tag[k];
			r.out_buffer    = req_bh[k];
			r.seek_distance = seek_from_head(req_block[k]);
			sum = {1'b0, seek_sum} + (TOTAL_W + 1)'(r.seek_distance);
			seek_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
			head_pos = req_block[k];
			for (int i = k; i + 1 < req_count; i++) begin
				req_block[i] = req_block[i+1];
				req_read[i]  = req_read[i+1];
				req_tag[i]   = req_tag[i+1];
				req_bh[i]    = req_bh[i+1];
			end
			req_count--;
		end
		r.total_seek    = seek_sum;
		r.pending_count = req_count[PENDING_W-1:0];
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] seen);
		if (mismatches < MAX_LINES)
			$display("check: result %0d %s: expected %0h, got %0h", n_results, what, want, seen);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t seen;
		if (!arst_n) begin
			req_count    = 0;
			head_pos     = '0;
			seek_sum     = '0;
			cur_policy   = POL_FCFS;
			pending_results.delete();
			mismatches   = 0;
			outstanding  = 0;
			n_results    = 0;
			n_dispatched = 0;
			n_rejected   = 0;
			n_empty      = 0;
		end else begin
			if (cfg_wen)
				cur_policy = cfg_wdata;
			if (s_tvalid && s_tready)
				pending_results.push_back(predict_command(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				seen.status        = m_tuser;
				seen.out_block     = m_tdata[23:0];
				seen.out_is_read   = m_tdata[24];
				seen.out_task_tag  = m_tdata[32:25];
				seen.out_buffer    = m_tdata[48:33];
				seen.seek_distance = m_tdata[72:49];
				seen.total_seek    = m_tdata[112:73];
				seen.pending_count = m_tdata[117:113];
				if (pending_results.size() == 0) begin
					report("arrived with none expected, status", '0, 64'(seen.status));
				end else begin
					want = pending_results.pop_front();
					if (seen.status !== want.status)
						report("status", 64'(want.status), 64'(seen.status));
					if (seen.out_block !== want.out_block)
						report("out_block", 64'(want.out_block), 64'(seen.out_block));
					if (seen.out_is_read !== want.out_is_read)
						report("out_is_read", 64'(want.out_is_read), 64'(seen.out_is_read));
					if (seen.out_task_tag !== want.out_task_tag)
						report("out_task_tag", 64'(want.out_task_tag), 64'(seen.out_task_tag));
					if (seen.out_buffer !== want.out_buffer)
						report("out_buffer", 64'(want.out_buffer), 64'(seen.out_buffer));
					if (seen.seek_distance !== want.seek_distance)
						report("seek_distance", 64'(want.seek_distance),
							64'(seen.seek_distance));
					if (seen.total_seek !== want.total_seek)
						report("total_seek", 64'(want.total_seek), 64'(seen.total_seek));
					if (seen.pending_count !== want.pending_count)
						report("pending_count", 64'(want.pending_count),
							64'(seen.pending_count));
					case (want.status)
						ST_DISPATCHED: n_dispatched++;
						ST_REJECTED:   n_rejected++;
						ST_EMPTY:      n_empty++;
						default:       ;
					endcase
				end
				n_results++;
			end
			outstanding = pending_results.size();
		end
	end

endmodule

/* sim/disk_request_scheduler_core_test.sv */
// Testbench top for the disk request scheduler: clock, reset, policy writes and
// command stimulus with random gaps and back-pressure; verdict from the checker.
// Depends on drs_pkg, disk_request_scheduler_core and disk_request_scheduler_checker.
module disk_request_scheduler_core_test;
	import drs_pkg::*;

	localparam int                  IDLE_PCT     = 21;
	localparam int                  HOLD_CYCLES  = 300;
	localparam int                  N_PHASES     = 9;
	localparam int                  PHASE_ITEMS  = 100;
	localparam logic [POLICY_W-1:0] POL_UNUSED   = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [POLICY_W-1:0]  cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	int mismatches, outstanding, n_results, n_dispatched, n_rejected, n_empty;
	bit no_idle   = 1'b0;
	bit hold_req  = 1'b0;
	int n_configs = 0;

	disk_request_scheduler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	disk_request_scheduler_checker scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.n_results    (n_results),
		.n_dispatched (n_dispatched),
		.n_rejected   (n_rejected),
		.n_empty      (n_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_command(input logic cmd, input logic rd, input logic [IN_BLOCK_W-1:0] blk,
			input logic [TAG_W-1:0] tag, input logic [BUF_W-1:0] handle);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tuser  = cmd;
		s_tdata  = '0;
		s_tdata[0]     = rd;
		s_tdata[24:1]  = blk;
		s_tdata[32:25] = tag;
		s_tdata[48:33] = handle;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic enqueue_request(input logic [IN_BLOCK_W-1:0] blk);
		send_command(CMD_ENQUEUE, 1'($urandom_range(1)), blk, TAG_W'($urandom),
			BUF_W'($urandom));
	endtask

	task automatic dispatch_request();
		send_command(CMD_DISPATCH, 1'($urandom_range(1)), IN_BLOCK_W'($urandom),
			TAG_W'($urandom), BUF_W'($urandom));
	endtask

	// policy may only change with no transaction in flight
	task automatic set_policy(input logic [POLICY_W-1:0] p);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_wdata = p;
		cfg_wen   = 1'b1;
		@(negedge clk);
		cfg_wen   = 1'b0;
		n_configs++;
	endtask

	// mix of spread-out, clustered (ties) and edge blocks
	function automatic logic [IN_BLOCK_W-1:0] pick_block();
		logic [IN_BLOCK_W-1:0] b;
		case ($urandom_range(3))
			0: b = IN_BLOCK_W'($urandom);
			1: b = IN_BLOCK_W'($urandom_range(63));
			2: begin
				case ($urandom_range(3))
					0: b = '0;
					1: b = '1;
					2: b = 24'h000001;
					default: b = 24'hFFFFFE;
				endcase
			end
			default: b = 24'h7FFFF0 + IN_BLOCK_W'($urandom_range(31));
		endcase
		return b;
	endfunction

	initial begin
		logic [POLICY_W-1:0] phase_policy [N_PHASES];
		int                  enq_pct;
		phase_policy = '{POL_CSCAN, POL_SSTF, POL_FCFS, POL_UNUSED, POL_SSTF,
			POL_CSCAN, POL_FCFS, POL_SSTF, POL_CSCAN};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_policy(POL_FCFS);
		// directed: empty dispatch, fill with edge values, overflow, then drain a few
		dispatch_request();
		for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
			case (i)
				0: send_command(CMD_ENQUEUE, 1'b0, '0, '0, '0);
				1: send_command(CMD_ENQUEUE, 1'b1, '1, '1, '1);
				2: send_command(CMD_ENQUEUE, 1'b1, 24'h000040, 8'h55, 16'hAAAA);
				3: send_command(CMD_ENQUEUE, 1'b0, 24'h000040, 8'hAA, 16'h5555);
				default: enqueue_request(pick_block());
			endcase
		end
		send_command(CMD_ENQUEUE, 1'b1, 24'h123456, 8'h77, 16'hBEEF);
		repeat (4) dispatch_request();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_policy(phase_policy[ph]);
			case (ph % 3)
				0: enq_pct = 55;
				1: enq_pct = 75;
				default: enq_pct = 35;
			endcase
			no_idle = (ph == 4);
			if (ph == 1)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < enq_pct)
					enqueue_request(pick_block());
				else
					dispatch_request();
			end
		end
		no_idle = 1'b0;

		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);

		$display("run: %0d results checked across %0d policy writes (all codes, incl. unused)",
			n_results, n_configs);
		$display("run: %0d dispatches, %0d enqueues rejected on full queue, %0d empty dispatches",
			n_dispatched, n_rejected, n_empty);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
